### rtl/core/fixed_string_distance_scorer_defines.svh
// ---------------------------------------------------------------------------
// Fixed string distance scorer: assertion macros
// Shared property macros for the checker; clk and rst are taken from scope.
// ---------------------------------------------------------------------------
`ifndef FIXED_STRING_DISTANCE_SCORER_DEFINES_SVH
`define FIXED_STRING_DISTANCE_SCORER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSDS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSDS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/fsds_pkg.sv
// ---------------------------------------------------------------------------
// Fixed string distance scorer package
// Shared types, constants and the edit distance cell function.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fsds_pkg;

  localparam int StrBytes  = 16;
  localparam int ByteBits  = 8;
  localparam int CellW     = 5;
  localparam int DistW     = 8;
  localparam int AddrW     = 5;
  localparam int DataW     = 64;
  // One stage for each anti-diagonal from sum 2 to sum 32 of the score matrix.
  localparam int OsaStages = 2 * StrBytes - 1;
  localparam int HamStages = 3;
  localparam int HamDelay  = OsaStages - HamStages;
  // Accepting edge to the edge that takes the result.
  localparam int Latency   = OsaStages + 2;

  typedef logic [StrBytes-1:0][ByteBits-1:0] byte_arr_t;
  typedef logic [StrBytes:0][CellW-1:0]      diag_t;
  // Element 0 is the newest anti-diagonal, element 3 the oldest.
  typedef diag_t [3:0]                       win_t;

  typedef enum logic [1:0] {
    MODE_BIT  = 2'd0,
    MODE_BYTE = 2'd1,
    MODE_OSA  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    REG_TARGET_LOW  = 2'd0,
    REG_TARGET_HIGH = 2'd1,
    REG_SCORE_MODE  = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic  valid;
    mode_t mode;
  } ctrl_t;

  typedef struct packed {
    logic [DistW-1:0] bits;
    logic [CellW-1:0] bytes;
  } ham_t;

  function automatic logic [CellW-1:0] osa_cell(
    input logic [CellW-1:0] sub,
    input logic [CellW-1:0] up,
    input logic [CellW-1:0] left,
    input logic [CellW-1:0] trans,
    input logic             cost,
    input logic             trans_ok
  );
    logic [CellW:0] v;
    logic [CellW:0] t;
    logic [CellW:0] u;
    logic [CellW:0] l;
    v = {1'b0, sub} + {{CellW{1'b0}}, cost};
    t = {1'b0, trans} + {{CellW{1'b0}}, 1'b1};
    u = {1'b0, up} + {{CellW{1'b0}}, 1'b1};
    l = {1'b0, left} + {{CellW{1'b0}}, 1'b1};
    if (trans_ok && (v > t)) begin
      v = t;
    end
    if (v > u) begin
      v = u;
    end
    if (v > l) begin
      v = l;
    end
    return v[CellW-1:0];
  endfunction

endpackage

### rtl/core/fixed_string_distance_scorer.sv
// ---------------------------------------------------------------------------
// Fixed string distance scorer
// Scores a 16-byte candidate against a configured 16-byte target.
// ---------------------------------------------------------------------------
// The target and the score mode are written over the APB-style port at
// byte addresses 0, 8 and 16; they may only change while no transaction is
// in flight. A candidate is taken at each rising edge where start is high
// and busy is low, and busy is low whenever reset is not asserted, so a new
// candidate can enter in every cycle. Throughput is one candidate per cycle.
// The score leaves on distance with done high for exactly one cycle. The
// path from the accepting edge runs through an input register, the edit
// distance array, which computes one anti-diagonal of the 17 by 17 score
// matrix per stage (31 stages), and an output register; the Hamming counts
// run alongside and are delayed to the same latency. Synchronous reset
// clears the configuration registers and every pipeline valid bit, so
// transactions in flight are dropped. The receiver cannot stall the block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fixed_string_distance_scorer (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsds_pkg::AddrW-1:0]   paddr,
  input  logic [fsds_pkg::DataW-1:0]   pwdata,
  output logic [fsds_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  input  logic                         start,
  output logic                         busy,
  input  logic [63:0]                  candidate_low,
  input  logic [63:0]                  candidate_high,
  output logic                         done,
  output logic [fsds_pkg::DistW-1:0]   distance
);

  fsds_pkg::byte_arr_t        target;
  fsds_pkg::mode_t            mode;
  fsds_pkg::ctrl_t            ctrl_a;
  fsds_pkg::byte_arr_t        cand_a;
  fsds_pkg::ctrl_t            osa_ctrl;
  logic [fsds_pkg::CellW-1:0] osa_dist;
  fsds_pkg::ham_t             ham;
  logic [fsds_pkg::DistW-1:0] distance_next;

  fsds_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .target  (target),
    .mode    (mode)
  );

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl_a.valid <= 1'b0;
    end else begin
      ctrl_a.valid <= start && !busy;
    end
    ctrl_a.mode <= mode;
    cand_a      <= {candidate_high, candidate_low};
  end

  fsds_osa u_osa (
    .clk      (clk),
    .rst      (rst),
    .in_ctrl  (ctrl_a),
    .in_cand  (cand_a),
    .target   (target),
    .out_ctrl (osa_ctrl),
    .out_dist (osa_dist)
  );

  fsds_ham u_ham (
    .clk    (clk),
    .cand   (cand_a),
    .target (target),
    .result (ham)
  );

  always_comb begin
    case (osa_ctrl.mode)
      fsds_pkg::MODE_BYTE: distance_next = {3'b000, ham.bytes};
      fsds_pkg::MODE_OSA:  distance_next = {3'b000, osa_dist};
      default:             distance_next = ham.bits;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= osa_ctrl.valid;
    end
    distance <= distance_next;
  end

endmodule

### rtl/core/fsds_regs.sv
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the target string and the score mode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsds_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsds_pkg::AddrW-1:0]   paddr,
  input  logic [fsds_pkg::DataW-1:0]   pwdata,
  output logic [fsds_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output fsds_pkg::byte_arr_t          target,
  output fsds_pkg::mode_t              mode
);

  logic [fsds_pkg::DataW-1:0] target_low;
  logic [fsds_pkg::DataW-1:0] target_high;
  fsds_pkg::mode_t            score_mode;
  fsds_pkg::reg_idx_t         idx;
  logic                       wr_en;

  assign pready = 1'b1;
  assign idx    = fsds_pkg::reg_idx_t'(paddr[fsds_pkg::AddrW-1:3]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_low  <= '0;
      target_high <= '0;
      score_mode  <= fsds_pkg::MODE_BIT;
    end else if (wr_en) begin
      case (idx)
        fsds_pkg::REG_TARGET_LOW:  target_low  <= pwdata;
        fsds_pkg::REG_TARGET_HIGH: target_high <= pwdata;
        fsds_pkg::REG_SCORE_MODE:  score_mode  <= fsds_pkg::mode_t'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fsds_pkg::REG_TARGET_LOW:  prdata = target_low;
      fsds_pkg::REG_TARGET_HIGH: prdata = target_high;
      fsds_pkg::REG_SCORE_MODE:  prdata = {{(fsds_pkg::DataW-2){1'b0}}, score_mode};
      default:                   prdata = '0;
    endcase
  end

  assign target = {target_high, target_low};
  assign mode   = score_mode;

endmodule

### rtl/core/fsds_ham.sv
// ---------------------------------------------------------------------------
// Hamming counters
// Bit and byte mismatch counts, pipelined and delayed to match the edit
// distance array.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsds_ham (
  input  logic                clk,
  input  fsds_pkg::byte_arr_t cand,
  input  fsds_pkg::byte_arr_t target,
  output fsds_pkg::ham_t      result
);

  localparam int Groups = fsds_pkg::StrBytes / 4;

  logic [fsds_pkg::StrBytes-1:0][3:0] pc_s1;
  logic [fsds_pkg::StrBytes-1:0]      diff_s1;
  logic [fsds_pkg::StrBytes-1:0][3:0] pc_next;
  logic [Groups-1:0][5:0]             gbits_s2;
  logic [Groups-1:0][2:0]             gbytes_s2;
  logic [Groups-1:0][5:0]             gbits_next;
  logic [Groups-1:0][2:0]             gbytes_next;
  fsds_pkg::ham_t                     sum_s3;
  fsds_pkg::ham_t                     sum_next;
  fsds_pkg::ham_t                     dly [0:fsds_pkg::HamDelay-1];

  always_comb begin
    for (int k = 0; k < fsds_pkg::StrBytes; k++) begin
      pc_next[k] = '0;
      for (int b = 0; b < fsds_pkg::ByteBits; b++) begin
        pc_next[k] = pc_next[k] + {3'b000, cand[k][b] ^ target[k][b]};
      end
    end
  end

  always_comb begin
    for (int g = 0; g < Groups; g++) begin
      gbits_next[g]  = '0;
      gbytes_next[g] = '0;
      for (int m = 0; m < 4; m++) begin
        gbits_next[g]  = gbits_next[g] + {2'b00, pc_s1[4*g+m]};
        gbytes_next[g] = gbytes_next[g] + {2'b00, diff_s1[4*g+m]};
      end
    end
  end

  always_comb begin
    sum_next = '0;
    for (int g = 0; g < Groups; g++) begin
      sum_next.bits  = sum_next.bits + {2'b00, gbits_s2[g]};
      sum_next.bytes = sum_next.bytes + {2'b00, gbytes_s2[g]};
    end
  end

  always_ff @(posedge clk) begin
    pc_s1 <= pc_next;
    for (int k = 0; k < fsds_pkg::StrBytes; k++) begin
      diff_s1[k] <= (cand[k] != target[k]);
    end
    gbits_s2  <= gbits_next;
    gbytes_s2 <= gbytes_next;
    sum_s3    <= sum_next;
    dly[0]    <= sum_s3;
    for (int k = 1; k < fsds_pkg::HamDelay; k++) begin
      dly[k] <= dly[k-1];
    end
  end

  assign result = dly[fsds_pkg::HamDelay-1];

endmodule

### rtl/core/fsds_osa.sv
// ---------------------------------------------------------------------------
// Edit distance wavefront
// Restricted transposition edit distance, one anti-diagonal of the score
// matrix per pipeline stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fsds_osa (
  input  logic                       clk,
  input  logic                       rst,
  input  fsds_pkg::ctrl_t            in_ctrl,
  input  fsds_pkg::byte_arr_t        in_cand,
  input  fsds_pkg::byte_arr_t        target,
  output fsds_pkg::ctrl_t            out_ctrl,
  output logic [fsds_pkg::CellW-1:0] out_dist
);

  localparam int N = fsds_pkg::StrBytes;

  // Entry i of a diagonal with sum s holds matrix cell (i, s - i).
  fsds_pkg::ctrl_t     ctrl_q [1:fsds_pkg::OsaStages];
  fsds_pkg::byte_arr_t cand_q [1:fsds_pkg::OsaStages];
  fsds_pkg::win_t      win_q  [1:fsds_pkg::OsaStages];

  for (genvar k = 0; k < fsds_pkg::OsaStages; k++) begin : g_stage
    localparam int S = k + 2;
    fsds_pkg::ctrl_t     c_in;
    fsds_pkg::byte_arr_t s_in;
    fsds_pkg::win_t      w_in;
    fsds_pkg::diag_t     nd;

    if (k == 0) begin : g_first
      // Diagonal of sum one is all ones, diagonal of sum zero all zeros.
      assign c_in = in_ctrl;
      assign s_in = in_cand;
      assign w_in = {{(3*(N+1)*fsds_pkg::CellW){1'b0}},
                     {(N+1){fsds_pkg::CellW'(1)}}};
    end else begin : g_rest
      assign c_in = ctrl_q[k];
      assign s_in = cand_q[k];
      assign w_in = win_q[k];
    end

    for (genvar i = 0; i <= N; i++) begin : g_cell
      localparam int J = S - i;
      if ((J < 0) || (J > N)) begin : g_out
        assign nd[i] = '0;
      end else if ((i == 0) || (J == 0)) begin : g_edge
        assign nd[i] = fsds_pkg::CellW'(S);
      end else begin : g_core
        logic                       cost;
        logic                       tok;
        logic [fsds_pkg::CellW-1:0] tval;
        assign cost = (s_in[i-1] != target[J-1]);
        if ((i >= 2) && (J >= 2)) begin : g_tr
          assign tok  = (s_in[i-2] == target[J-1]) && (s_in[i-1] == target[J-2]);
          assign tval = w_in[3][i-2];
        end else begin : g_no_tr
          assign tok  = 1'b0;
          assign tval = '0;
        end
        assign nd[i] = fsds_pkg::osa_cell(w_in[1][i-1], w_in[0][i-1], w_in[0][i],
                                          tval, cost, tok);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctrl_q[k+1].valid <= 1'b0;
      end else begin
        ctrl_q[k+1].valid <= c_in.valid;
      end
      ctrl_q[k+1].mode <= c_in.mode;
      cand_q[k+1]      <= s_in;
      win_q[k+1]       <= {w_in[2:0], nd};
    end
  end

  assign out_ctrl = ctrl_q[fsds_pkg::OsaStages];
  assign out_dist = win_q[fsds_pkg::OsaStages][0][N];

endmodule

### rtl/core/fsds_checker.sv
// ---------------------------------------------------------------------------
// Fixed string distance scorer checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_string_distance_scorer_defines.svh"

module fsds_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [fsds_pkg::AddrW-1:0]   paddr,
  input logic [fsds_pkg::DataW-1:0]   pwdata,
  input logic [fsds_pkg::DataW-1:0]   prdata,
  input logic                         pready,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic [fsds_pkg::DistW-1:0]   distance
);

  // Every result must trace back to a transaction a fixed latency earlier.
  `FSDS_ASSERT_IMP(a_done_latency, done, $past(start && !busy, fsds_pkg::Latency), "result without matching transaction")

  `FSDS_ASSERT_IMP(a_dist_range, done, distance <= 8'd128, "distance out of range")

  `FSDS_ASSERT_IMP(a_reset_quiet, $past(rst), !done, "result straight after reset")

  // A target_low write must read back unchanged on the following cycle.
  `FSDS_ASSERT_NXT(a_readback, psel && penable && pwrite && pready && (paddr[4:3] == fsds_pkg::REG_TARGET_LOW), !(psel && !pwrite && (paddr[4:3] == fsds_pkg::REG_TARGET_LOW)) || (prdata == $past(pwdata)), "target_low read back differs")

endmodule

bind fixed_string_distance_scorer fsds_checker u_checker (.*);

### bench/score_checker.sv
// ---------------------------------------------------------------------------
// Distance score checker
// Watches the register port and both transaction channels of the scorer.
// It keeps its own copy of the target and the mode, predicts every score,
// and compares each result with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module score_checker
  import fsds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  input  logic [DataW-1:0]   prdata,
  input  logic               pready,
  input  logic               start,
  input  logic               busy,
  input  logic [63:0]        candidate_low,
  input  logic [63:0]        candidate_high,
  input  logic               done,
  input  logic [DistW-1:0]   distance,
  output int                 errors,
  output int                 pending
);

  logic [63:0]      target_lo;
  logic [63:0]      target_hi;
  mode_t            mode;
  logic [DistW-1:0] expected_scores[$];

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  function automatic logic [DistW-1:0] osa_score(input byte_arr_t c, input byte_arr_t t);
    int older[StrBytes+1];
    int prev[StrBytes+1];
    int cur[StrBytes+1];
    int v;
    for (int j = 0; j <= StrBytes; j++) begin
      prev[j]  = j;
      older[j] = j;
    end
    for (int i = 0; i < StrBytes; i++) begin
      cur[0] = i + 1;
      for (int j = 0; j < StrBytes; j++) begin
        v = prev[j] + ((c[i] != t[j]) ? 1 : 0);
        // Adjacent transposition is only allowed on untouched pairs.
        if (i > 0 && j > 0 && c[i-1] == t[j] && c[i] == t[j-1] && v > older[j-1] + 1) begin
          v = older[j-1] + 1;
        end
        if (v > prev[j+1] + 1) begin
          v = prev[j+1] + 1;
        end
        if (v > cur[j] + 1) begin
          v = cur[j] + 1;
        end
        cur[j+1] = v;
      end
      older = prev;
      prev  = cur;
    end
    return DistW'(prev[StrBytes]);
  endfunction

  function automatic logic [DistW-1:0] predict_score(input logic [63:0] lo,
                                                      input logic [63:0] hi);
    byte_arr_t cand;
    byte_arr_t targ;
    int        n;
    cand = byte_arr_t'({hi, lo});
    targ = byte_arr_t'({target_hi, target_lo});
    n    = 0;
    case (mode)
      MODE_BYTE: begin
        for (int k = 0; k < StrBytes; k++) begin
          if (cand[k] != targ[k]) begin
            n++;
          end
        end
        return DistW'(n);
      end
      MODE_OSA: begin
        return osa_score(cand, targ);
      end
      // The unnamed fourth mode scores as the bit count.
      default: begin
        return DistW'($countones({hi, lo} ^ {target_hi, target_lo}));
      end
    endcase
  endfunction

  always @(posedge clk) begin
    logic [DistW-1:0] want;
    logic [DataW-1:0] reg_value;
    if (rst) begin
      target_lo = '0;
      target_hi = '0;
      mode      = MODE_BIT;
      expected_scores.delete();
    end else begin
      if (psel && penable && pready) begin
        reg_value = '0;
        case (reg_idx_t'(paddr[AddrW-1:3]))
          REG_TARGET_LOW: begin
            if (pwrite) target_lo = pwdata;
            reg_value = target_lo;
          end
          REG_TARGET_HIGH: begin
            if (pwrite) target_hi = pwdata;
            reg_value = target_hi;
          end
          REG_SCORE_MODE: begin
            if (pwrite) mode = mode_t'(pwdata[1:0]);
            reg_value = DataW'(mode);
          end
          default: begin
            // Writes beyond the register list are dropped.
          end
        endcase
        if (!pwrite && paddr[AddrW-1:3] <= REG_SCORE_MODE && prdata !== reg_value) begin
          report_mismatch($sformatf("read of address %0d gave %h, expected %h",
                                    paddr, prdata, reg_value));
        end
      end
      if (done === 1'b1) begin
        if (expected_scores.size() == 0) begin
          report_mismatch($sformatf("result %0d with no transaction outstanding", distance));
        end else begin
          want = expected_scores.pop_front();
          if (distance !== want) begin
            report_mismatch($sformatf("distance %0d, expected %0d", distance, want));
          end
        end
      end else if (done !== 1'b0) begin
        report_mismatch("done is not a known value");
      end
      if (start && !busy) begin
        expected_scores.push_back(predict_score(candidate_low, candidate_high));
      end
    end
    pending = expected_scores.size();
  end

endmodule

### bench/tb.sv
// ---------------------------------------------------------------------------
// Fixed string distance scorer testbench
// Drives register setups and candidate transactions into the scorer, with
// random gaps and a pause until the pipeline empties. A checker module
// beside the block predicts and compares every score.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fsds_pkg::*;

  localparam logic [1:0]       ModeAlias   = 2'd3;
  localparam logic [AddrW-1:0] UnusedAddr  = 5'd24;
  localparam logic [127:0]     DirTarget   = 128'h504f4e4d4c4b4a494847464544434241;
  localparam logic [127:0]     DirSwapped  = 128'h504f4e4d4c4b4a494847464445434241;
  localparam logic [127:0]     DirShifted  = 128'h51504f4e4d4c4b4a4948474645444342;
  localparam logic [127:0]     DirReversed = 128'h4142434445464748494a4b4c4d4e4f50;
  localparam logic [127:0]     DirOneSub   = 128'h504f4e4d4c4b4a495a47464544434241;
  localparam int               PhaseCount  = 8;
  localparam int               PhaseItems  = 118;

  typedef enum int {TGT_RANDOM, TGT_ALPHA, TGT_ZERO, TGT_ONES} tgt_kind_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [AddrW-1:0]   paddr;
  logic [DataW-1:0]   pwdata;
  logic [DataW-1:0]   prdata;
  logic               pready;
  logic               start;
  logic               busy;
  logic [63:0]        candidate_low;
  logic [63:0]        candidate_high;
  logic               done;
  logic [DistW-1:0]   distance;
  int                 errors;
  int                 pending;

  fixed_string_distance_scorer dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .candidate_low, .candidate_high, .done, .distance
  );

  score_checker u_checker (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .start, .busy, .candidate_low, .candidate_high, .done, .distance,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** fixed_string_distance_scorer: FAILED **");
    $finish;
  end

  function automatic logic [127:0] random_wide();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic logic [7:0] alpha_byte();
    return 8'h61 + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [127:0] make_target(input tgt_kind_t kind);
    byte_arr_t s;
    case (kind)
      TGT_ZERO: s = '0;
      TGT_ONES: s = '1;
      TGT_ALPHA: begin
        for (int k = 0; k < StrBytes; k++) s[k] = alpha_byte();
      end
      default: s = byte_arr_t'(random_wide());
    endcase
    return s;
  endfunction

  // Most candidates are the target with a few edits, so the edit distance
  // array sees short, realistic distances as well as the wide ones.
  function automatic logic [127:0] make_candidate(input logic [127:0] tgt);
    byte_arr_t s;
    int        roll;
    int        edits;
    int        p;
    roll = $urandom_range(0, 99);
    if (roll < 15) return random_wide();
    if (roll < 25) begin
      for (int k = 0; k < StrBytes; k++) s[k] = alpha_byte();
      return s;
    end
    s     = byte_arr_t'(tgt);
    edits = $urandom_range(0, 4);
    for (int e = 0; e < edits; e++) begin
      p = $urandom_range(0, StrBytes - 2);
      case ($urandom_range(0, 4))
        0: s[p] = 8'($urandom);
        1: s[p] = s[p] ^ (8'h01 << $urandom_range(0, 7));
        2: begin
          s[p]   = s[p] ^ s[p+1];
          s[p+1] = s[p] ^ s[p+1];
          s[p]   = s[p] ^ s[p+1];
        end
        3: begin
          for (int k = p; k < StrBytes - 1; k++) s[k] = s[k+1];
          s[StrBytes-1] = ($urandom_range(0, 1) != 0) ? alpha_byte() : 8'($urandom);
        end
        default: begin
          for (int k = StrBytes - 1; k > p; k--) s[k] = s[k-1];
          s[p] = ($urandom_range(0, 1) != 0) ? alpha_byte() : 8'($urandom);
        end
      endcase
    end
    return s;
  endfunction

  task automatic apb_access(input logic wr, input logic [AddrW-1:0] addr,
                            input logic [DataW-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic read_back_all();
    apb_access(1'b0, AddrW'({REG_TARGET_LOW, 3'b000}), '0);
    apb_access(1'b0, AddrW'({REG_TARGET_HIGH, 3'b000}), '0);
    apb_access(1'b0, AddrW'({REG_SCORE_MODE, 3'b000}), '0);
  endtask

  // Upper bits of the mode word are noise that the block must discard.
  task automatic configure(input logic [127:0] tgt, input logic [1:0] mode_code);
    apb_access(1'b1, AddrW'({REG_TARGET_LOW, 3'b000}), tgt[63:0]);
    apb_access(1'b1, AddrW'({REG_TARGET_HIGH, 3'b000}), tgt[127:64]);
    apb_access(1'b1, AddrW'({REG_SCORE_MODE, 3'b000}),
               {$urandom, 30'($urandom), mode_code});
    read_back_all();
  endtask

  // start is left high so that back-to-back transactions need no toggle.
  task automatic send(input logic [127:0] cand);
    @(negedge clk);
    start          = 1'b1;
    candidate_low  = cand[63:0];
    candidate_high = cand[127:64];
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_gap(input int cycles);
    logic [127:0] noise;
    repeat (cycles) begin
      @(negedge clk);
      noise          = random_wide();
      start          = 1'b0;
      candidate_low  = noise[63:0];
      candidate_high = noise[127:64];
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    tgt_kind_t    phase_tgt[PhaseCount];
    logic [1:0]   phase_mode[PhaseCount];
    logic [127:0] tgt;
    rst            = 1'b1;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    start          = 1'b0;
    candidate_low  = '0;
    candidate_high = '0;
    phase_tgt  = '{TGT_RANDOM, TGT_ALPHA, TGT_ONES, TGT_ZERO,
                   TGT_ZERO, TGT_RANDOM, TGT_ALPHA, TGT_RANDOM};
    phase_mode = '{MODE_BIT, ModeAlias, MODE_OSA, MODE_BYTE,
                   MODE_BIT, ModeAlias, MODE_OSA, MODE_BYTE};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset values: zero target, bit count.
    read_back_all();
    send('0);
    send('1);
    drain();

    configure(DirTarget, MODE_BYTE);
    send(DirTarget);
    send(DirOneSub);
    send(~DirTarget);
    drain();

    configure(DirTarget, MODE_OSA);
    send(DirTarget);
    send(DirSwapped);
    send(DirShifted);
    send(DirReversed);
    send(~DirTarget);
    send('0);
    drain();

    configure(DirTarget, ModeAlias);
    send(DirTarget);
    send(~DirTarget);
    send(DirTarget ^ 128'h1);
    drain();

    // A write past the register list must leave every register alone.
    apb_access(1'b1, UnusedAddr, {$urandom, $urandom});
    read_back_all();
    send(DirTarget ^ {1'b1, 127'h0});
    drain();

    for (int ph = 0; ph < PhaseCount; ph++) begin
      tgt = make_target(phase_tgt[ph]);
      configure(tgt, phase_mode[ph]);
      for (int n = 0; n < PhaseItems; n++) begin
        // Phase two runs flat out to keep the whole pipeline full.
        if (ph != 2 && $urandom_range(0, 99) < 12) begin
          idle_gap($urandom_range(1, 2));
        end
        if (ph == 5 && n == PhaseItems / 2) begin
          drain();
        end
        send(make_candidate(tgt));
      end
      drain();
    end

    // Catch any stray result after the last expected one.
    repeat (Latency + 8) @(posedge clk);
    if (errors == 0) begin
      $display("** fixed_string_distance_scorer: PASSED **");
    end else begin
      $display("** fixed_string_distance_scorer: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/fsds_pkg.sv
rtl/core/fsds_regs.sv
rtl/core/fsds_ham.sv
rtl/core/fsds_osa.sv
rtl/core/fixed_string_distance_scorer.sv
rtl/core/fsds_checker.sv
bench/score_checker.sv
bench/tb.sv
